>>> rtl/ppc_pkg.sv
`default_nettype none

package ppc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LENGTH  = 3'd0,
        CFG_MIN_LENGTH  = 3'd1,
        CFG_MIN_UPPER   = 3'd2,
        CFG_MIN_SPECIAL = 3'd3,
        CFG_MIN_DIGITS  = 3'd4,
        CFG_MAX_RUN     = 3'd5
    } t_cfg_idx;

    // verdict codes
    localparam int VERDICT_W = 4;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_PASS        = 4'd0,
        VERDICT_BAD_CHAR    = 4'd1,
        VERDICT_SHORT       = 4'd2,
        VERDICT_LONG        = 4'd3,
        VERDICT_FEW_UPPER   = 4'd4,
        VERDICT_FEW_DIGITS  = 4'd5,
        VERDICT_RUN         = 4'd6,
        VERDICT_FEW_SPECIAL = 4'd7,
        VERDICT_BAD_POLICY  = 4'd8
    } t_verdict;

    localparam int CHAR_W = 8;
    localparam int REG_W  = 8;
    localparam int RUN_W  = 8;

    localparam int LENGTH_LIMIT_DEFAULT = 255;

    // register reset values
    localparam logic [REG_W-1:0] RST_MAX_LENGTH  = 8'd64;
    localparam logic [REG_W-1:0] RST_MIN_LENGTH  = 8'd8;
    localparam logic [REG_W-1:0] RST_MIN_UPPER   = 8'd0;
    localparam logic [REG_W-1:0] RST_MIN_SPECIAL = 8'd0;
    localparam logic [REG_W-1:0] RST_MIN_DIGITS  = 8'd0;
    localparam logic [REG_W-1:0] RST_MAX_RUN     = 8'd0;

    // character class bounds
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

endpackage

`default_nettype wire

>>> rtl/password_policy_checker_top.sv
`default_nettype none

// Password policy checker. A password is streamed in one transaction per
// character (i_has_char = 1) and closed by a transaction with i_last = 1, which
// may itself carry a character or be an empty end marker. On every closing
// transaction the block delivers exactly one verdict (0 pass, 1 bad char,
// 2 short, 3 long, 4 few upper, 5 few digits, 6 run, 7 few special, 8 bad
// policy, checked in the order 8,1,2,3,4,5,6,7) and then starts the next
// password from a clean state; other transactions produce no output. A new
// transaction is taken every clock cycle while the input side is not stalled.
// A closing transaction passes through the input register, then through the
// counter update and checks into the result register. The input side stalls
// only while a closing transaction waits behind a stalled, still full result
// register. Policy registers are written through the cfg port (always ready)
// and should only change while no password is in flight. Length and class
// counters saturate at LENGTH_LIMIT; a character beyond that makes the
// password too long.
module password_policy_checker_top #(
    parameter int LENGTH_LIMIT = ppc_pkg::LENGTH_LIMIT_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // character input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ppc_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic                          i_has_char,
    input  wire logic                          i_last,
    // verdict output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ppc_pkg::VERDICT_W-1:0]      o_verdict,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ppc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ppc_pkg::REG_W-1:0]     i_cfg_data
);
    import ppc_pkg::*;

    // counter width follows the saturation limit
    localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);
    // compare width covers both the counters and the 8-bit registers
    localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam int SUM_W = CNT_W + 2;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LENGTH_LIMIT);

    // policy registers
    logic [REG_W-1:0] r_max_length, r_min_length, r_min_upper;
    logic [REG_W-1:0] r_min_special, r_min_digits, r_max_run;

    // input register
    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_has_char;
    logic              r_s1_last;

    // per-password state
    logic [CNT_W-1:0]  r_length_count, n_length_count;
    logic [CNT_W-1:0]  r_upper_count, n_upper_count;
    logic [CNT_W-1:0]  r_digit_count, n_digit_count;
    logic [CNT_W-1:0]  r_lower_count, n_lower_count;
    logic [RUN_W-1:0]  r_run_count, n_run_count;
    logic [CHAR_W-1:0] r_previous_char, n_previous_char;
    logic              r_bad_char_seen, n_bad_char_seen;
    logic              r_run_exceeded, n_run_exceeded;
    logic              r_length_over, n_length_over;

    // result register
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_verdict;
    t_verdict             n_verdict;

    logic out_free;
    logic s1_go;
    logic s1_take;

    logic is_bad, is_upper, is_digit, is_lower, is_repeat;
    logic [SUM_W-1:0] classed;
    logic [SUM_W-1:0] len_ext;
    logic [CNT_W-1:0] special;

    // the result slot frees up when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // only a closing transaction needs the result slot
    assign s1_go    = r_s1_valid && (!r_s1_last || out_free);
    assign s1_take  = s1_go && r_s1_has_char;

    assign o_in_stall  = r_s1_valid && !s1_go;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_cfg_ready = 1'b1;

    // policy register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length  <= RST_MAX_LENGTH;
            r_min_length  <= RST_MIN_LENGTH;
            r_min_upper   <= RST_MIN_UPPER;
            r_min_special <= RST_MIN_SPECIAL;
            r_min_digits  <= RST_MIN_DIGITS;
            r_max_run     <= RST_MAX_RUN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                CFG_MIN_LENGTH:  r_min_length  <= i_cfg_data;
                CFG_MIN_UPPER:   r_min_upper   <= i_cfg_data;
                CFG_MIN_SPECIAL: r_min_special <= i_cfg_data;
                CFG_MIN_DIGITS:  r_min_digits  <= i_cfg_data;
                CFG_MAX_RUN:     r_max_run     <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // input register: loads whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_s1_char     <= i_char_code;
            r_s1_has_char <= i_has_char;
            r_s1_last     <= i_last;
        end
    end

    // character classes
    assign is_bad    = (r_s1_char < CH_SPACE) || (r_s1_char > CH_TILDE);
    assign is_upper  = (r_s1_char >= CH_UP_A)  && (r_s1_char <= CH_UP_Z);
    assign is_digit  = (r_s1_char >= CH_DIG_0) && (r_s1_char <= CH_DIG_9);
    assign is_lower  = (r_s1_char >= CH_LO_A)  && (r_s1_char <= CH_LO_Z);
    assign is_repeat = (r_s1_char == r_previous_char);

    // state update for one character
    always_comb begin
        n_length_count  = r_length_count;
        n_upper_count   = r_upper_count;
        n_digit_count   = r_digit_count;
        n_lower_count   = r_lower_count;
        n_run_count     = r_run_count;
        n_previous_char = r_previous_char;
        n_bad_char_seen = r_bad_char_seen;
        n_run_exceeded  = r_run_exceeded;
        n_length_over   = r_length_over;
        if (r_s1_has_char) begin
            if (r_length_count >= CNT_LIMIT) begin
                n_length_over = 1'b1;
            end else begin
                n_length_count = r_length_count + 1'b1;
            end
            if (is_bad) begin
                n_bad_char_seen = 1'b1;
            end
            if (is_upper && (r_upper_count < CNT_LIMIT)) begin
                n_upper_count = r_upper_count + 1'b1;
            end
            if (is_digit && (r_digit_count < CNT_LIMIT)) begin
                n_digit_count = r_digit_count + 1'b1;
            end
            if (is_lower && (r_lower_count < CNT_LIMIT)) begin
                n_lower_count = r_lower_count + 1'b1;
            end
            if (is_repeat) begin
                if (r_run_count < RUN_MAX) begin
                    n_run_count = r_run_count + 1'b1;
                end
                if ((n_run_count == r_max_run) || (r_max_run <= RUN_W'(1))) begin
                    n_run_exceeded = 1'b1;
                end
            end else begin
                n_run_count = RUN_W'(1);
            end
            n_previous_char = r_s1_char;
        end
    end

    // special count, clamped at zero
    assign classed = SUM_W'(n_upper_count) + SUM_W'(n_digit_count) + SUM_W'(n_lower_count);
    assign len_ext = SUM_W'(n_length_count);
    assign special = (len_ext > classed) ? CNT_W'(len_ext - classed) : '0;

    // verdict in priority order
    always_comb begin
        if (r_max_length == '0) begin
            n_verdict = VERDICT_BAD_POLICY;
        end else if (n_bad_char_seen) begin
            n_verdict = VERDICT_BAD_CHAR;
        end else if (CMP_W'(n_length_count) < CMP_W'(r_min_length)) begin
            n_verdict = VERDICT_SHORT;
        end else if (n_length_over || (CMP_W'(n_length_count) > CMP_W'(r_max_length))) begin
            n_verdict = VERDICT_LONG;
        end else if (CMP_W'(n_upper_count) < CMP_W'(r_min_upper)) begin
            n_verdict = VERDICT_FEW_UPPER;
        end else if (CMP_W'(n_digit_count) < CMP_W'(r_min_digits)) begin
            n_verdict = VERDICT_FEW_DIGITS;
        end else if (n_run_exceeded) begin
            n_verdict = VERDICT_RUN;
        end else if (CMP_W'(special) < CMP_W'(r_min_special)) begin
            n_verdict = VERDICT_FEW_SPECIAL;
        end else begin
            n_verdict = VERDICT_PASS;
        end
    end

    // per-password state: updated on a character, cleared on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_go && r_s1_last)) begin
            r_length_count  <= '0;
            r_upper_count   <= '0;
            r_digit_count   <= '0;
            r_lower_count   <= '0;
            r_run_count     <= RUN_W'(1);
            r_previous_char <= '0;
            r_bad_char_seen <= 1'b0;
            r_run_exceeded  <= 1'b0;
            r_length_over   <= 1'b0;
        end else if (s1_take) begin
            r_length_count  <= n_length_count;
            r_upper_count   <= n_upper_count;
            r_digit_count   <= n_digit_count;
            r_lower_count   <= n_lower_count;
            r_run_count     <= n_run_count;
            r_previous_char <= n_previous_char;
            r_bad_char_seen <= n_bad_char_seen;
            r_run_exceeded  <= n_run_exceeded;
            r_length_over   <= n_length_over;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_verdict <= n_verdict;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ppc_checker.sv
`default_nettype none

module ppc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [ppc_pkg::VERDICT_W-1:0] o_verdict
);
    import ppc_pkg::*;

    // no verdict is left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // verdict is always one of the defined codes
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= VERDICT_BAD_POLICY))
        else $error("verdict code out of range");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_verdict_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_verdict))
        else $error("verdict changed while stalled");

endmodule

bind password_policy_checker_top ppc_checker u_ppc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_verdict   (o_verdict)
);

`default_nettype wire

>>> bench/tb_password_policy_checker_top.sv
`timescale 1ns / 100ps

module tb_password_policy_checker_top;
    import ppc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_WAIT       = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 540;
    localparam int PHASE_PWS      = 8;
    localparam int REPORT_LINES   = 40;
    localparam int NUM_REGS       = 6;
    localparam int SAT_LIMIT      = LENGTH_LIMIT_DEFAULT;
    // index past the last policy register, the block ignores it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // block ports, every input known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 i_has_char  = 1'b0;
    logic                 i_last      = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [VERDICT_W-1:0] o_verdict;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [REG_W-1:0]     i_cfg_data  = '0;

    // policy copy and per-password counters of the predictor
    logic [REG_W-1:0]  policy [NUM_REGS];
    int unsigned       pw_length, pw_upper, pw_digits, pw_lower, pw_run;
    logic [CHAR_W-1:0] pw_prev;
    bit                pw_bad_char, pw_run_hit, pw_overflow;
    t_verdict          verdicts_due [$];

    // bookkeeping shared by the sender, the receiver and the checker
    int mismatch_count = 0;
    int cycle_count    = 0;
    int idle_cycles    = 0;
    int rx_release     = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    bit in_gaps_on     = 1'b1;
    bit out_gaps_on    = 1'b1;

    password_policy_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_has_char  (i_has_char),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (o_verdict),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_password();
        pw_length   = 0;
        pw_upper    = 0;
        pw_digits   = 0;
        pw_lower    = 0;
        pw_run      = 1;
        pw_prev     = '0;
        pw_bad_char = 1'b0;
        pw_run_hit  = 1'b0;
        pw_overflow = 1'b0;
    endfunction

    function automatic int unsigned sat_bump(int unsigned v);
        return (v < SAT_LIMIT) ? v + 1 : v;
    endfunction

    // fold one accepted transaction into the counters, queue a verdict on last
    function automatic void predict_item(logic [CHAR_W-1:0] c, bit has_char, bit last);
        t_verdict    v;
        int unsigned classed;
        int unsigned special;
        if (has_char) begin
            // a byte arriving at the limit marks the password too long
            if (pw_length >= SAT_LIMIT) pw_overflow = 1'b1;
            pw_length = sat_bump(pw_length);
            if (c < CH_SPACE || c > CH_TILDE) pw_bad_char = 1'b1;
            if (c >= CH_UP_A && c <= CH_UP_Z) pw_upper = sat_bump(pw_upper);
            if (c >= CH_DIG_0 && c <= CH_DIG_9) pw_digits = sat_bump(pw_digits);
            if (c >= CH_LO_A && c <= CH_LO_Z) pw_lower = sat_bump(pw_lower);
            if (c == pw_prev) begin
                if (pw_run < RUN_MAX) pw_run++;
                // exact hit of the run limit, or any repeat when the limit is 0 or 1
                if (pw_run == policy[CFG_MAX_RUN] || policy[CFG_MAX_RUN] <= 1) pw_run_hit = 1'b1;
            end else begin
                pw_run = 1;
            end
            pw_prev = c;
        end
        if (!last) return;
        classed = pw_upper + pw_digits + pw_lower;
        special = (pw_length > classed) ? pw_length - classed : 0;
        // fixed priority: policy, bad char, short, long, upper, digits, run, special
        if (policy[CFG_MAX_LENGTH] == 0) v = VERDICT_BAD_POLICY;
        else if (pw_bad_char) v = VERDICT_BAD_CHAR;
        else if (pw_length < policy[CFG_MIN_LENGTH]) v = VERDICT_SHORT;
        else if (pw_overflow || pw_length > policy[CFG_MAX_LENGTH]) v = VERDICT_LONG;
        else if (pw_upper < policy[CFG_MIN_UPPER]) v = VERDICT_FEW_UPPER;
        else if (pw_digits < policy[CFG_MIN_DIGITS]) v = VERDICT_FEW_DIGITS;
        else if (pw_run_hit) v = VERDICT_RUN;
        else if (special < policy[CFG_MIN_SPECIAL]) v = VERDICT_FEW_SPECIAL;
        else v = VERDICT_PASS;
        verdicts_due.push_back(v);
        clear_password();
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    // idle cycles before a transaction, none while idling is switched off
    function automatic int draw_wait(bit on);
        return on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // mostly small register values, sometimes the extremes
    function automatic logic [REG_W-1:0] pick_setting(int hi);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return REG_W'($urandom_range(0, hi));
        endcase
    endfunction

    // password byte: mostly alphanumerics and punctuation, some repeats,
    // a few bytes outside printable ascii
    function automatic logic [CHAR_W-1:0] pick_byte(logic [CHAR_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return CHAR_W'($urandom_range(CH_UP_A, CH_UP_Z));
        if (r < 38) return CHAR_W'($urandom_range(CH_DIG_0, CH_DIG_9));
        if (r < 62) return CHAR_W'($urandom_range(CH_LO_A, CH_LO_Z));
        if (r < 80 || (r < 96 && prev == '0)) begin
            case ($urandom_range(0, 3))
                0: return CHAR_W'($urandom_range(CH_SPACE, CH_DIG_0 - 1));
                1: return CHAR_W'($urandom_range(CH_DIG_9 + 1, CH_UP_A - 1));
                2: return CHAR_W'($urandom_range(CH_UP_Z + 1, CH_LO_A - 1));
                default: return CHAR_W'($urandom_range(CH_LO_Z + 1, CH_TILDE));
            endcase
        end
        if (r < 96) return prev;
        if (r < 98) return $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, CH_SPACE - 1))
                                                : CHAR_W'(CH_TILDE + 1);
        return CHAR_W'($urandom_range(CH_TILDE + 2, 8'hFF));
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic report(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // one input transaction; returns right after the accepting edge
    task automatic send_item(logic [CHAR_W-1:0] code, bit has_char, bit last);
        int gap;
        gap = draw_wait(in_gaps_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= code;
        i_has_char  <= has_char;
        i_last      <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(code, has_char, last);
    endtask

    // whole password, closed on its final byte or by an empty end item
    task automatic send_text(string s, bit empty_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, !empty_end && i == s.len() - 1);
        if (empty_end || s.len() == 0) send_item(CHAR_W'($urandom), 1'b0, 1'b1);
    endtask

    // drop valid, let every verdict come back, then cover the pipeline latency
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one config transaction; leaves valid high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_MAX_RUN) policy[idx] = data;
    endtask

    task automatic set_policy(logic [REG_W-1:0] max_len, logic [REG_W-1:0] min_len,
                              logic [REG_W-1:0] min_up, logic [REG_W-1:0] min_spec,
                              logic [REG_W-1:0] min_dig, logic [REG_W-1:0] run_lim);
        wait_idle();
        write_reg(CFG_MAX_LENGTH, max_len);
        write_reg(CFG_MIN_LENGTH, min_len);
        write_reg(CFG_MIN_UPPER, min_up);
        write_reg(CFG_MIN_SPECIAL, min_spec);
        write_reg(CFG_MIN_DIGITS, min_dig);
        write_reg(CFG_MAX_RUN, run_lim);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall after each verdict, plus long hold-offs on request
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : verdict_receiver
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        i_out_stall <= (hold_left > 0) || (cycle_count < rx_release);
        if (hold_left > 0) hold_left--;
    end

    // ------------------------------------------------------------------
    // checker and watchdog, both on the rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        cycle_count++;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (o_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    report($sformatf("verdict %0d with no password closed", o_verdict));
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_verdict !== want)
                        report($sformatf("verdict %0d, expected %0d (%s)",
                                         o_verdict, want, want.name()));
                end
                rx_release = cycle_count + draw_wait(out_gaps_on);
            end
            // nothing moved on any channel for too long
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // policy straight out of reset: min length 8, no repeats allowed
    task automatic test_reset_policy();
        send_item(CHAR_W'($urandom), 1'b0, 1'b0);   // empty item without last, ignored
        send_text("", 1'b1);                // empty password, short
        send_text("Pa5sw0rd", 1'b0);        // pass
        send_text("Pass1234", 1'b0);        // repeated s, run
    endtask

    // every verdict with a tight policy, plus the invalid policy
    task automatic test_policy_registers();
        wait_idle();
        write_reg(CFG_SPARE, REG_W'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        set_policy(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_text("A1!", 1'b0);             // zero max length, bad policy
        set_policy(8'd4, 8'd1, 8'd1, 8'd1, 8'd1, 8'd3);
        send_item(8'h00, 1'b1, 1'b1);       // zero byte equal to cleared previous byte
        send_item(8'hFF, 1'b1, 1'b1);       // top byte, bad char
        send_text("A", 1'b0);               // few digits
        send_text("1", 1'b1);               // few upper, closed by an empty end item
        send_text("", 1'b1);                // short
        send_text("A1~b!", 1'b0);           // long
        send_text("AAA1", 1'b0);            // run reaches the limit of 3
        send_text("A1 b", 1'b0);            // space counts as special, pass
        send_text("A1bc", 1'b0);            // few special
    endtask

    // length and class counters at the limit, run counter at 255
    task automatic test_counter_saturation();
        set_policy(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
        // exactly the limit of alternating 'x' and 'Y', pass
        for (int i = 0; i < SAT_LIMIT; i++)
            send_item((i % 2) ? 8'h59 : 8'h78, 1'b1, i == SAT_LIMIT - 1);
        // one byte past the limit, long
        for (int i = 0; i <= SAT_LIMIT; i++)
            send_item((i % 2) ? 8'h59 : 8'h78, 1'b1, i == SAT_LIMIT);
        // 255 copies of '7' hit a run limit of 255
        for (int i = 0; i < SAT_LIMIT; i++)
            send_item(8'h37, 1'b1, i == SAT_LIMIT - 1);
    endtask

    // receiver holds off while short passwords keep coming, input must stall
    task automatic test_output_backpressure();
        set_policy(8'd16, 8'd2, 8'd0, 8'd0, 8'd1, 8'd2);
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
            if (i % 2) send_text("a1", i % 3 == 0);
            else       send_text("9", i % 3 == 0);
        end
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    // random passwords under a new policy every few passwords
    task automatic test_random_passwords();
        int                sent;
        int                len;
        int                pw;
        bit                on_char;
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] prev;
        sent = 0;
        for (pw = 0; sent < RANDOM_ITEMS; pw++) begin
            if (pw % PHASE_PWS == 0) begin
                case (pw / PHASE_PWS)
                    0: set_policy('0, '0, '0, '0, '0, '0);
                    1: set_policy('1, '1, '1, '1, '1, '1);
                    default: set_policy(pick_setting(24), pick_setting(10), pick_setting(3),
                                        pick_setting(3), pick_setting(3), pick_setting(4));
                endcase
                // stretches with and without idling on either side
                in_gaps_on  = $urandom_range(0, 3) != 0;
                out_gaps_on = $urandom_range(0, 3) != 0;
            end
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
            on_char = (len > 0) && ($urandom_range(0, 1) == 1);
            prev    = '0;
            for (int i = 0; i < len; i++) begin
                // stray empty item in the middle of a password
                if ($urandom_range(0, 19) == 0) send_item(CHAR_W'($urandom), 1'b0, 1'b0);
                c = pick_byte(prev);
                send_item(c, 1'b1, on_char && i == len - 1);
                prev = c;
                sent++;
            end
            if (!on_char) begin
                send_item(CHAR_W'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        policy[CFG_MAX_LENGTH]  = RST_MAX_LENGTH;
        policy[CFG_MIN_LENGTH]  = RST_MIN_LENGTH;
        policy[CFG_MIN_UPPER]   = RST_MIN_UPPER;
        policy[CFG_MIN_SPECIAL] = RST_MIN_SPECIAL;
        policy[CFG_MIN_DIGITS]  = RST_MIN_DIGITS;
        policy[CFG_MAX_RUN]     = RST_MAX_RUN;
        clear_password();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_policy();
        test_policy_registers();
        test_counter_saturation();
        test_output_backpressure();
        test_random_passwords();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
